[sv/slc_pkg.sv]
// Shared constants and types for the segment rectangle clipper.
`default_nettype none

package slc_pkg;

    // Window edge register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_RIGHT  = 2'd1,
        REG_BOTTOM = 2'd2,
        REG_TOP    = 2'd3
    } reg_index_t;

    // Edges are walked in the order left, right, bottom, top
    localparam int NUM_EDGES = 4;
    localparam int BOUND_LEFT   = 0;
    localparam int BOUND_RIGHT  = 1;
    localparam int BOUND_BOTTOM = 2;
    localparam int BOUND_TOP    = 3;

    // Quotient bits resolved per divider pipeline stage
    localparam int DIV_STEPS_PER_STAGE = 2;

endpackage

`default_nettype wire

[sv/segment_rect_clip.sv]
// Liang-Barsky segment clipper against a configurable axis-aligned window.
// Stages in order: input register, divider stages, resolve, multiply, output.
// Throughput: one segment per cycle while out_ready holds; the divider lanes are fully pipelined.
// Each stage holds its own valid bit, so bubbles close up under output stall.
// Reset (rst_n, async, active low) empties the pipe and sets the window to full range.
`default_nettype none

module segment_rect_clip #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  slc_pkg::reg_index_t          cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         visible,
    output logic signed [COORD_BITS-1:0] clip_start_x,
    output logic signed [COORD_BITS-1:0] clip_start_y,
    output logic signed [COORD_BITS-1:0] clip_end_x,
    output logic signed [COORD_BITS-1:0] clip_end_y
);
    import slc_pkg::*;

    localparam int DW     = COORD_BITS + 1;
    localparam int QW     = FRAC_BITS + 1;
    localparam int TW     = FRAC_BITS + 2;
    localparam int MW     = TW + DW;
    localparam int PW     = MW + 1;
    localparam int ND     = (FRAC_BITS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
    localparam int ST_RES = ND + 1;
    localparam int ST_MUL = ND + 2;
    localparam int ST_OUT = ND + 3;
    localparam int NS     = ND + 4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [DW-1:0]         dx;
        logic signed [DW-1:0]         dy;
        logic [NUM_EDGES-1:0]         pz;
        logic [NUM_EDGES-1:0]         qneg;
        logic [NUM_EDGES-1:0]         pneg;
    } side_t;

    // Window registers
    logic signed [COORD_BITS-1:0] left_reg, right_reg, bottom_reg, top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= {1'b1, {(COORD_BITS-1){1'b0}}};
            right_reg  <= {1'b0, {(COORD_BITS-1){1'b1}}};
            bottom_reg <= {1'b1, {(COORD_BITS-1){1'b0}}};
            top_reg    <= {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_LEFT:   left_reg   <= cfg_data;
                REG_RIGHT:  right_reg  <= cfg_data;
                REG_BOTTOM: bottom_reg <= cfg_data;
                REG_TOP:    top_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-stage valid bits and ready chain
    logic [NS-1:0] valid_reg;
    logic [NS:0]   rdy;

    assign rdy[NS] = out_ready;
    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_rdy
            assign rdy[g] = !valid_reg[g] || rdy[g+1];
        end
    endgenerate
    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Stage 0: deltas, p and q per edge, magnitudes and signs
    side_t                side_next;
    logic [DW-1:0]        num_next [NUM_EDGES];
    logic [DW-1:0]        den_next [NUM_EDGES];
    side_t                side_reg [ND+1];
    logic [DW-1:0]        num_reg  [NUM_EDGES];
    logic [DW-1:0]        den_reg  [NUM_EDGES];

    always_comb
    begin
        logic signed [DW-1:0] sxe, sye, dxv, dyv;
        logic signed [DW-1:0] p [NUM_EDGES];
        logic signed [DW-1:0] q [NUM_EDGES];
        sxe = DW'(start_x);
        sye = DW'(start_y);
        dxv = DW'(end_x) - sxe;
        dyv = DW'(end_y) - sye;
        p[BOUND_LEFT]   = -dxv;
        q[BOUND_LEFT]   = sxe - DW'(left_reg);
        p[BOUND_RIGHT]  = dxv;
        q[BOUND_RIGHT]  = DW'(right_reg) - sxe;
        p[BOUND_BOTTOM] = -dyv;
        q[BOUND_BOTTOM] = sye - DW'(bottom_reg);
        p[BOUND_TOP]    = dyv;
        q[BOUND_TOP]    = DW'(top_reg) - sye;
        side_next.sx = start_x;
        side_next.sy = start_y;
        side_next.dx = dxv;
        side_next.dy = dyv;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            side_next.pz[e]   = (p[e] == '0);
            side_next.qneg[e] = q[e][DW-1];
            side_next.pneg[e] = p[e][DW-1];
            num_next[e] = q[e][DW-1] ? -q[e] : q[e];
            den_next[e] = p[e][DW-1] ? -p[e] : p[e];
        end
    end

    // Sideband registers run alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            side_reg[0] <= side_next;
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                num_reg[e] <= num_next[e];
                den_reg[e] <= den_next[e];
            end
        end
        for (int k = 1; k <= ND; k++)
        begin
            if (rdy[k])
                side_reg[k] <= side_reg[k-1];
        end
    end

    // One divider lane per edge
    logic [QW-1:0]        quot_w [NUM_EDGES];
    logic [NUM_EDGES-1:0] over_w;

    generate
        for (g = 0; g < NUM_EDGES; g++) begin : g_div
            slc_div #(
                .MAG_W     (DW),
                .FRAC_BITS (FRAC_BITS)
            ) u_div (
                .clk  (clk),
                .adv  (rdy[ND:1]),
                .num  (num_reg[g]),
                .den  (den_reg[g]),
                .quot (quot_w[g]),
                .over (over_w[g])
            );
        end
    endgenerate

    // Resolve stage: narrow [t0,t1] edge by edge, in order
    logic                 res_ok_next;
    logic [QW-1:0]        res_t0_next, res_t1_next;
    logic                 res_ok_reg;
    logic [QW-1:0]        res_t0_reg, res_t1_reg;
    side_t                res_side_reg;

    always_comb
    begin
        side_t                sd;
        logic signed [TW-1:0] one, mag, r, t0, t1;
        logic                 ok;
        sd  = side_reg[ND];
        one = TW'(1) << FRAC_BITS;
        t0  = '0;
        t1  = one;
        ok  = 1'b1;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            // ratios beyond [0,1] saturate; only their side of the range matters
            mag = over_w[e] ? (one + TW'(1)) : TW'(quot_w[e]);
            r   = (sd.qneg[e] ^ sd.pneg[e]) ? -mag : mag;
            if (ok)
            begin
                if (sd.pz[e])
                begin
                    if (sd.qneg[e])
                        ok = 1'b0;
                end
                else if (sd.pneg[e])
                begin
                    if (r > t1)
                        ok = 1'b0;
                    else if (r > t0)
                        t0 = r;
                end
                else
                begin
                    if (r < t0)
                        ok = 1'b0;
                    else if (r < t1)
                        t1 = r;
                end
            end
        end
        res_ok_next = ok;
        res_t0_next = t0[QW-1:0];
        res_t1_next = t1[QW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_RES])
        begin
            res_ok_reg   <= res_ok_next;
            res_t0_reg   <= res_t0_next;
            res_t1_reg   <= res_t1_next;
            res_side_reg <= side_reg[ND];
        end
    end

    // Multiply stage: t times delta for both endpoints
    logic signed [MW-1:0]         mul_next [NUM_EDGES];
    logic signed [MW-1:0]         mul_reg  [NUM_EDGES];
    logic signed [COORD_BITS-1:0] mul_sx_reg, mul_sy_reg;
    logic                         mul_ok_reg;

    always_comb
    begin
        logic signed [TW-1:0] t0s, t1s;
        t0s = $signed({1'b0, res_t0_reg});
        t1s = $signed({1'b0, res_t1_reg});
        mul_next[0] = t0s * res_side_reg.dx;
        mul_next[1] = t0s * res_side_reg.dy;
        mul_next[2] = t1s * res_side_reg.dx;
        mul_next[3] = t1s * res_side_reg.dy;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_MUL])
        begin
            for (int i = 0; i < NUM_EDGES; i++)
                mul_reg[i] <= mul_next[i];
            mul_sx_reg <= res_side_reg.sx;
            mul_sy_reg <= res_side_reg.sy;
            mul_ok_reg <= res_ok_reg;
        end
    end

    // Output stage: round to nearest, add start, zero on reject
    logic signed [COORD_BITS-1:0] pt_next [NUM_EDGES];
    logic                         vis_reg;
    logic signed [COORD_BITS-1:0] pt_reg  [NUM_EDGES];

    always_comb
    begin
        logic signed [PW-1:0] sum;
        logic signed [PW-1:0] sh;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            sum = PW'(mul_reg[i]) + (PW'(1) << (FRAC_BITS - 1));
            sh  = sum >>> FRAC_BITS;
            if (!mul_ok_reg)
                pt_next[i] = '0;
            else if (i == 0 || i == 2)
                pt_next[i] = mul_sx_reg + sh[COORD_BITS-1:0];
            else
                pt_next[i] = mul_sy_reg + sh[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_OUT])
        begin
            vis_reg <= mul_ok_reg;
            for (int i = 0; i < NUM_EDGES; i++)
                pt_reg[i] <= pt_next[i];
        end
    end

    assign out_valid    = valid_reg[ST_OUT];
    assign visible      = vis_reg;
    assign clip_start_x = pt_reg[0];
    assign clip_start_y = pt_reg[1];
    assign clip_end_x   = pt_reg[2];
    assign clip_end_y   = pt_reg[3];

`ifndef SYNTH
    // rejected segments carry zero endpoints
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !visible) |-> (clip_start_x == '0 && clip_start_y == '0
            && clip_end_x == '0 && clip_end_y == '0))
        else $error("rejected segment with non-zero endpoints");

    // an empty first stage always takes a transaction
    a_head_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> in_ready)
        else $error("input blocked with empty first stage");

    // a blocked resolve stage keeps its item
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_RES] && !rdy[ST_MUL]) |=> valid_reg[ST_RES])
        else $error("resolve stage dropped an item under stall");
`endif

endmodule

`default_nettype wire

[sv/slc_div.sv]
// Pipelined restoring divider giving |q| * 2^FRAC_BITS / |p| for |q| <= |p|.
`default_nettype none

module slc_div #(
    parameter int MAG_W     = 17,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic [(FRAC_BITS + slc_pkg::DIV_STEPS_PER_STAGE - 1)
                  / slc_pkg::DIV_STEPS_PER_STAGE - 1:0] adv,
    input  logic [MAG_W-1:0]     num,
    input  logic [MAG_W-1:0]     den,
    output logic [FRAC_BITS:0]   quot,
    output logic                 over
);
    import slc_pkg::*;

    localparam int NST = (FRAC_BITS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
    localparam int QW  = FRAC_BITS + 1;
    localparam int RW  = MAG_W + 1;

    logic [RW-1:0]    rem_reg  [NST];
    logic [QW-1:0]    quo_reg  [NST];
    logic [MAG_W-1:0] den_reg  [NST];
    logic             over_reg [NST];

    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_stage
            // previous stage, clamped so stage 0 never indexes below the array
            localparam int KP = (k == 0) ? 0 : k - 1;

            logic [RW-1:0]    rem_next;
            logic [QW-1:0]    quo_next;
            logic [MAG_W-1:0] den_next;
            logic             over_next;

            // Stage 0 also takes the integer bit and the overrange flag
            always_comb
            begin
                logic [RW-1:0] r;
                logic [QW-1:0] qv;
                logic [RW-1:0] sh;
                sh = '0;
                if (k == 0)
                begin
                    den_next  = den;
                    over_next = (num > den);
                    if (num >= den)
                    begin
                        r  = {1'b0, num - den};
                        qv = QW'(1);
                    end
                    else
                    begin
                        r  = {1'b0, num};
                        qv = '0;
                    end
                end
                else
                begin
                    den_next  = den_reg[KP];
                    over_next = over_reg[KP];
                    r         = rem_reg[KP];
                    qv        = quo_reg[KP];
                end
                // fractional bits, one compare and subtract each
                for (int j = 0; j < DIV_STEPS_PER_STAGE; j++)
                begin
                    if (k * DIV_STEPS_PER_STAGE + j < FRAC_BITS)
                    begin
                        sh = {r[MAG_W-1:0], 1'b0};
                        if (sh >= {1'b0, den_next})
                        begin
                            r  = sh - {1'b0, den_next};
                            qv = {qv[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            r  = sh;
                            qv = {qv[QW-2:0], 1'b0};
                        end
                    end
                end
                rem_next = r;
                quo_next = qv;
            end

            always_ff @(posedge clk)
            begin
                if (adv[k])
                begin
                    rem_reg[k]  <= rem_next;
                    quo_reg[k]  <= quo_next;
                    den_reg[k]  <= den_next;
                    over_reg[k] <= over_next;
                end
            end
        end
    endgenerate

    assign quot = quo_reg[NST-1];
    assign over = over_reg[NST-1];

endmodule

`default_nettype wire
